### hw/rtl/ac3_sync_frame_parser_assert.svh
// ----------------------------------------------------------------------------
// AC-3 sync frame parser assertion macros
// Shared concurrent assertion forms, clocked on clk and quiet during reset.
// ----------------------------------------------------------------------------
`ifndef AC3_SYNC_FRAME_PARSER_ASSERT_SVH
`define AC3_SYNC_FRAME_PARSER_ASSERT_SVH

// Consequence must hold in the same cycle as the antecedent.
`define AC3SFP_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequence must hold in the cycle after the antecedent.
`define AC3SFP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hw/rtl/ac3sfp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ac3sfp_pkg
// Types, constants and decode tables for the AC-3 sync frame parser.
// ----------------------------------------------------------------------------
package ac3sfp_pkg;

	localparam int HDR_LEN = 7;

	localparam logic [7:0] SYNC_HI = 8'h0B;
	localparam logic [7:0] SYNC_LO = 8'h77;
	localparam logic [7:0] LFE_BASE = 8'h10;

	localparam logic [1:0] RATE_RESERVED = 2'd3;
	localparam logic [5:0] NUM_SIZE_CODES = 6'd38;

	localparam logic [2:0] ACMOD_MONO = 3'd1;
	localparam logic [2:0] ACMOD_STEREO = 3'd2;

	// Header byte counts during the sync hunt.
	localparam logic [2:0] CNT_IDLE = 3'd0;
	localparam logic [2:0] CNT_SYNC1 = 3'd1;
	localparam logic [2:0] CNT_FULL = 3'd6;

	// Frame size in 16-bit words, indexed by size code and rate code
	// (48 kHz, 44.1 kHz, 32 kHz).
	localparam logic [10:0] SIZE_WORDS [38][3] = '{
		'{11'd64, 11'd69, 11'd96}, '{11'd64, 11'd70, 11'd96},
		'{11'd80, 11'd87, 11'd120}, '{11'd80, 11'd88, 11'd120},
		'{11'd96, 11'd104, 11'd144}, '{11'd96, 11'd105, 11'd144},
		'{11'd112, 11'd121, 11'd168}, '{11'd112, 11'd122, 11'd168},
		'{11'd128, 11'd139, 11'd192}, '{11'd128, 11'd140, 11'd192},
		'{11'd160, 11'd174, 11'd240}, '{11'd160, 11'd175, 11'd240},
		'{11'd192, 11'd208, 11'd288}, '{11'd192, 11'd209, 11'd288},
		'{11'd224, 11'd243, 11'd336}, '{11'd224, 11'd244, 11'd336},
		'{11'd256, 11'd278, 11'd384}, '{11'd256, 11'd279, 11'd384},
		'{11'd320, 11'd348, 11'd480}, '{11'd320, 11'd349, 11'd480},
		'{11'd384, 11'd417, 11'd576}, '{11'd384, 11'd418, 11'd576},
		'{11'd448, 11'd487, 11'd672}, '{11'd448, 11'd488, 11'd672},
		'{11'd512, 11'd557, 11'd768}, '{11'd512, 11'd558, 11'd768},
		'{11'd640, 11'd696, 11'd960}, '{11'd640, 11'd697, 11'd960},
		'{11'd768, 11'd835, 11'd1152}, '{11'd768, 11'd836, 11'd1152},
		'{11'd896, 11'd975, 11'd1344}, '{11'd896, 11'd976, 11'd1344},
		'{11'd1024, 11'd1114, 11'd1536}, '{11'd1024, 11'd1115, 11'd1536},
		'{11'd1152, 11'd1253, 11'd1728}, '{11'd1152, 11'd1254, 11'd1728},
		'{11'd1280, 11'd1393, 11'd1920}, '{11'd1280, 11'd1394, 11'd1920}
	};

	typedef logic [5:0][7:0] hold_t;
	typedef logic [6:0][7:0] hdr_t;

	typedef struct packed {
		logic [2:0] cnt;
		hold_t      hold;
	} hunt_t;

	typedef struct packed {
		logic [2:0]  chans;
		logic [1:0]  rate;
		logic [11:0] len;
	} meta_t;

	// Results of one parse step, handed to the output buffer.
	typedef struct packed {
		logic       emit_hdr;
		logic       emit_one;
		hdr_t       hdr;
		logic [7:0] data;
		logic       last;
		logic       changed;
		meta_t      meta;
	} res_t;

	function automatic logic [11:0] frame_bytes(logic [5:0] fsize, logic [1:0] rate);
		logic [10:0] w;
		w = '0;
		if (fsize < NUM_SIZE_CODES && rate != RATE_RESERVED) begin
			w = SIZE_WORDS[fsize][rate];
		end
		return {w, 1'b0};
	endfunction

	function automatic logic [2:0] chans_of(logic [2:0] acmod);
		logic [2:0] c;
		case (acmod)
			3'd0: c = 3'd2;
			3'd1: c = 3'd1;
			3'd2: c = 3'd2;
			3'd3: c = 3'd3;
			3'd4: c = 3'd3;
			3'd5: c = 3'd4;
			3'd6: c = 3'd4;
			default: c = 3'd5;
		endcase
		return c;
	endfunction

	// LFE flag position in header byte 6 moves down two bits per optional field.
	function automatic logic [7:0] lfe_mask(logic [2:0] acmod);
		logic [7:0] m;
		m = LFE_BASE;
		if (acmod[0] && acmod != ACMOD_MONO) begin
			m = m >> 2;
		end
		if (acmod[2]) begin
			m = m >> 2;
		end
		if (acmod == ACMOD_STEREO) begin
			m = m >> 2;
		end
		return m;
	endfunction

	// One byte of sync hunt and header gather, below the full-header point.
	function automatic hunt_t hunt_step(hunt_t h, logic [7:0] b);
		hunt_t n;
		n = h;
		case (h.cnt) inside
			CNT_IDLE: begin
				if (b == SYNC_HI) begin
					n.hold[0] = b;
					n.cnt = CNT_SYNC1;
				end
			end
			CNT_SYNC1: begin
				if (b == SYNC_LO) begin
					n.hold[1] = b;
					n.cnt = 3'd2;
				end else if (b != SYNC_HI) begin
					n.cnt = CNT_IDLE;
				end
			end
			[3'd2:3'd5]: begin
				n.hold[h.cnt] = b;
				n.cnt = h.cnt + 3'd1;
			end
			default: n.cnt = CNT_IDLE;
		endcase
		return n;
	endfunction

endpackage

### hw/rtl/ac3sfp_parse.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ac3sfp_parse
// Sync hunt, header decode, frame body count and skip count; one byte a step.
// ----------------------------------------------------------------------------
`include "ac3_sync_frame_parser_assert.svh"

module ac3sfp_parse (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [15:0]         cfg_data,
	input  logic                step,
	input  logic [7:0]          data_s1,
	output ac3sfp_pkg::res_t    res
);

	logic                body_q;
	logic [2:0]          cnt_q;
	ac3sfp_pkg::hold_t   hold_q;
	logic [11:0]         rem_q;
	ac3sfp_pkg::meta_t   cur_q;
	logic [2:0]          prev_chans_q;
	logic [1:0]          prev_rate_q;
	logic [15:0]         skip_q;
	logic                drop_q;

	ac3sfp_pkg::hdr_t    saved;
	logic [1:0]          rate;
	logic [5:0]          fsize;
	logic [2:0]          acmod;
	logic                bad;
	logic                lfe_on;
	logic [2:0]          chans;
	logic [11:0]         len;
	logic                changed;
	logic                full;
	logic [11:0]         rem_dec;
	logic                last;
	ac3sfp_pkg::hunt_t   plain;
	ac3sfp_pkg::hunt_t   replay;

	always_comb begin
		saved = {data_s1, hold_q};
		rate = saved[4][7:6];
		fsize = saved[4][5:0];
		acmod = saved[6][7:5];
		bad = (rate == ac3sfp_pkg::RATE_RESERVED) || (fsize >= ac3sfp_pkg::NUM_SIZE_CODES);
		lfe_on = (saved[6] & ac3sfp_pkg::lfe_mask(acmod)) != 8'd0;
		chans = ac3sfp_pkg::chans_of(acmod) + {2'b00, lfe_on};
		len = ac3sfp_pkg::frame_bytes(fsize, rate);
		changed = (chans != prev_chans_q) || (rate != prev_rate_q);
		full = !body_q && (cnt_q == ac3sfp_pkg::CNT_FULL);
		rem_dec = rem_q - {11'd0, rem_q != 12'd0};
		last = (rem_dec == 12'd0);

		plain = ac3sfp_pkg::hunt_step('{cnt: cnt_q, hold: hold_q}, data_s1);

		// Rejected header: hunt again through bytes 2..6 from an empty count.
		replay = '{cnt: ac3sfp_pkg::CNT_IDLE, hold: hold_q};
		for (int i = 2; i < ac3sfp_pkg::HDR_LEN; i++) begin
			replay = ac3sfp_pkg::hunt_step(replay, saved[i]);
		end

		res.emit_hdr = step && full && !bad && (skip_q == 16'd0);
		res.emit_one = step && body_q && !drop_q;
		res.hdr = saved;
		res.data = data_s1;
		res.last = last;
		res.changed = changed;
		if (full) begin
			res.meta = '{chans: chans, rate: rate, len: len};
		end else begin
			res.meta = cur_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			body_q <= 1'b0;
			cnt_q <= ac3sfp_pkg::CNT_IDLE;
			rem_q <= '0;
			cur_q <= '0;
			prev_chans_q <= 3'd0;
			prev_rate_q <= ac3sfp_pkg::RATE_RESERVED;
			drop_q <= 1'b0;
		end else if (step) begin
			if (body_q) begin
				rem_q <= rem_dec;
				if (last) begin
					body_q <= 1'b0;
					cnt_q <= ac3sfp_pkg::CNT_IDLE;
				end
			end else if (full) begin
				if (bad) begin
					cnt_q <= replay.cnt;
				end else begin
					cnt_q <= ac3sfp_pkg::CNT_IDLE;
					cur_q <= '{chans: chans, rate: rate, len: len};
					prev_chans_q <= chans;
					prev_rate_q <= rate;
					drop_q <= (skip_q != 16'd0);
					rem_q <= len - 12'(ac3sfp_pkg::HDR_LEN);
					body_q <= 1'b1;
				end
			end else begin
				cnt_q <= plain.cnt;
			end
		end
	end

	// Count down skipped frames; a register write reloads the count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skip_q <= '0;
		end else if (cfg_we) begin
			skip_q <= cfg_data;
		end else if (step && full && !bad && skip_q != 16'd0) begin
			skip_q <= skip_q - 16'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (step && !body_q) begin
			if (full && bad) begin
				hold_q <= replay.hold;
			end else if (!full) begin
				hold_q <= plain.hold;
			end
		end
	end

	`AC3SFP_ASSERT_SAME(a_body_has_bytes, body_q, rem_q != 12'd0,
		"frame body active with no bytes remaining")
	`AC3SFP_ASSERT_NEXT(a_frame_end_hunts, step && body_q && rem_q == 12'd1,
		!body_q && cnt_q == ac3sfp_pkg::CNT_IDLE, "frame end did not return to sync hunt")

endmodule

### hw/rtl/ac3sfp_out.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ac3sfp_out
// Result buffer: releases a seven-byte header burst or a single body byte.
// ----------------------------------------------------------------------------
`include "ac3_sync_frame_parser_assert.svh"

module ac3sfp_out (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  ac3sfp_pkg::res_t  res,
	output logic              free,
	output logic              frame_valid,
	input  logic              frame_ready,
	output logic [7:0]        frame_byte,
	output logic              frame_first,
	output logic              frame_last,
	output logic [2:0]        channel_count,
	output logic [1:0]        rate_code,
	output logic [11:0]       frame_length,
	output logic              format_changed
);

	logic [7:0]         hdr_buf_q [7];
	logic [2:0]         pend_q;
	logic [2:0]         idx_q;
	logic               first_q;
	logic               last_q;
	logic               chg_q;
	ac3sfp_pkg::meta_t  meta_q;
	logic               pop;

	assign frame_valid = (pend_q != 3'd0);
	assign pop = frame_valid && frame_ready;
	// Take new results when empty, or when the last held item leaves now.
	assign free = (pend_q == 3'd0) || (pend_q == 3'd1 && frame_ready);

	assign frame_byte = hdr_buf_q[idx_q];
	assign frame_first = first_q && (idx_q == 3'd0);
	assign frame_last = last_q && (pend_q == 3'd1);
	assign format_changed = chg_q && (idx_q == 3'd0);
	assign channel_count = meta_q.chans;
	assign rate_code = meta_q.rate;
	assign frame_length = meta_q.len;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 3'd0;
			idx_q <= 3'd0;
			first_q <= 1'b0;
			last_q <= 1'b0;
			chg_q <= 1'b0;
		end else if (load && res.emit_hdr) begin
			pend_q <= 3'(ac3sfp_pkg::HDR_LEN);
			idx_q <= 3'd0;
			first_q <= 1'b1;
			last_q <= 1'b0;
			chg_q <= res.changed;
		end else if (load && res.emit_one) begin
			pend_q <= 3'd1;
			idx_q <= 3'd0;
			first_q <= 1'b0;
			last_q <= res.last;
			chg_q <= 1'b0;
		end else if (pop) begin
			pend_q <= pend_q - 3'd1;
			idx_q <= idx_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load && res.emit_hdr) begin
			for (int i = 0; i < ac3sfp_pkg::HDR_LEN; i++) begin
				hdr_buf_q[i] <= res.hdr[i];
			end
			meta_q <= res.meta;
		end else if (load && res.emit_one) begin
			hdr_buf_q[0] <= res.data;
			meta_q <= res.meta;
		end
	end

	`AC3SFP_ASSERT_SAME(a_load_only_when_free, load && (res.emit_hdr || res.emit_one),
		free, "result loaded while buffer still holds items")
	`AC3SFP_ASSERT_NEXT(a_header_burst, load && res.emit_hdr,
		pend_q == 3'd7 && frame_first && !frame_last, "header burst not set up")

endmodule

### hw/rtl/ac3_sync_frame_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ac3_sync_frame_parser
// AC-3 sync frame parser: finds frames in a byte stream and forwards them.
// ----------------------------------------------------------------------------
// Usage:
//   stream channel: one AC-3 stream byte per item (stream_valid/stream_ready).
//   frame channel: one frame byte per item with first/last marks, channel
//     count, rate code (0=48 kHz, 1=44.1 kHz, 2=32 kHz), frame length and a
//     format-changed flag on the first byte (frame_valid/frame_ready).
//   cfg channel: writes frames_to_skip; always ready. Write only while idle.
// Timing:
//   A byte is held in the input register, then one parse step loads the
//   result buffer, which drives the frame channel from its registers.
//   Body bytes and hunted bytes flow at 1 item per cycle while frame_ready is
//   high and no header is draining. The seventh header byte of a forwarded
//   frame releases 7 items from the result buffer; the input waits meanwhile.
// Reset:
//   arst_n clears the hunt, the body count, the skip count (frames_to_skip
//   returns to 0) and marks the previous format as unknown.
// Stall:
//   A stalled receiver holds the buffered result; the parse step waits, the
//   input register fills and stream_ready drops. Nothing is lost.
// ----------------------------------------------------------------------------
module ac3_sync_frame_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data,
	input  logic        stream_valid,
	output logic        stream_ready,
	input  logic [7:0]  stream_byte,
	output logic        frame_valid,
	input  logic        frame_ready,
	output logic [7:0]  frame_byte,
	output logic        frame_first,
	output logic        frame_last,
	output logic [2:0]  channel_count,
	output logic [1:0]  rate_code,
	output logic [11:0] frame_length,
	output logic        format_changed
);

	logic              valid_s1;
	logic [7:0]        data_s1;
	logic              step;
	logic              free;
	ac3sfp_pkg::res_t  res;

	assign cfg_ready = 1'b1;

	// Advance the held byte only when the result buffer can take its results.
	assign step = valid_s1 && free;
	assign stream_ready = !valid_s1 || step;

	// Input register: hold the byte until the parse step consumes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (stream_valid && stream_ready) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (stream_valid && stream_ready) begin
			data_s1 <= stream_byte;
		end
	end

	// Sync hunt, header decode and frame tracking.
	ac3sfp_parse u_parse (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_valid && cfg_ready),
		.cfg_data (cfg_data),
		.step     (step),
		.data_s1  (data_s1),
		.res      (res)
	);

	// Result buffer and frame channel.
	ac3sfp_out u_out (
		.clk            (clk),
		.arst_n         (arst_n),
		.load           (step),
		.res            (res),
		.free           (free),
		.frame_valid    (frame_valid),
		.frame_ready    (frame_ready),
		.frame_byte     (frame_byte),
		.frame_first    (frame_first),
		.frame_last     (frame_last),
		.channel_count  (channel_count),
		.rate_code      (rate_code),
		.frame_length   (frame_length),
		.format_changed (format_changed)
	);

endmodule

### bench/tb_ac3_sync_frame_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ac3_sync_frame_parser
// Self-checking bench for the AC-3 sync frame parser. Feeds directed and
// random byte streams (frames, noise, broken sync words, reserved headers)
// under random stalls on both channels. A bit-exact model of the parser
// predicts every forwarded frame byte, and a checker compares each one.
// ----------------------------------------------------------------------------
module tb_ac3_sync_frame_parser;

	localparam int CLK_HALF      = 5;
	localparam int RESET_CYCLES  = 10;
	localparam int MAX_GAP       = 12;
	localparam int SETTLE_CYCLES = 8;
	localparam int TAIL_CYCLES   = 20;
	localparam int IDLE_LIMIT    = 2000;
	localparam int REPORT_LIMIT  = 10;
	localparam int RANDOM_SEQS   = 6;
	localparam int HDR_BYTES     = 7;
	localparam int SIZE_CODES    = 38;

	localparam logic [7:0] SYNC_FIRST  = 8'h0B;
	localparam logic [7:0] SYNC_SECOND = 8'h77;

	// Sample-rate codes as they sit in header byte 4, bits 7..6.
	localparam logic [1:0] RATE_48K = 2'd0;
	localparam logic [1:0] RATE_44K = 2'd1;
	localparam logic [1:0] RATE_32K = 2'd2;
	localparam logic [1:0] RATE_RSV = 2'd3;

	// Nominal bit rate in kbit/s for each pair of size codes.
	localparam int KBPS [19] = '{32, 40, 48, 56, 64, 80, 96, 112, 128, 160,
		192, 224, 256, 320, 384, 448, 512, 576, 640};

	typedef enum logic [1:0] {
		SEEK_SYNC,
		GATHER_HDR,
		IN_BODY
	} parse_phase_t;

	typedef enum logic [2:0] {
		ACM_DUAL,
		ACM_MONO,
		ACM_STEREO,
		ACM_3F,
		ACM_2F1R,
		ACM_3F1R,
		ACM_2F2R,
		ACM_3F2R
	} acmod_t;

	typedef struct packed {
		logic [7:0]  data;
		logic        first;
		logic        last;
		logic [2:0]  chans;
		logic [1:0]  rate;
		logic [11:0] len;
		logic        changed;
	} frame_beat_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [15:0] cfg_data = '0;
	logic        stream_valid = 1'b0;
	logic        stream_ready;
	logic [7:0]  stream_byte = '0;
	logic        frame_valid;
	logic        frame_ready = 1'b0;
	logic [7:0]  frame_byte;
	logic        frame_first;
	logic        frame_last;
	logic [2:0]  channel_count;
	logic [1:0]  rate_code;
	logic [11:0] frame_length;
	logic        format_changed;

	ac3_sync_frame_parser dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_data       (cfg_data),
		.stream_valid   (stream_valid),
		.stream_ready   (stream_ready),
		.stream_byte    (stream_byte),
		.frame_valid    (frame_valid),
		.frame_ready    (frame_ready),
		.frame_byte     (frame_byte),
		.frame_first    (frame_first),
		.frame_last     (frame_last),
		.channel_count  (channel_count),
		.rate_code      (rate_code),
		.frame_length   (frame_length),
		.format_changed (format_changed)
	);

	// ------------------------------------------------------------------------
	// Parser model state
	// ------------------------------------------------------------------------
	parse_phase_t phase;
	logic [7:0]   hdr_buf [HDR_BYTES];
	logic [2:0]   hdr_cnt;
	logic [11:0]  body_left;
	logic [11:0]  cur_len;
	logic [2:0]   cur_chans;
	logic [1:0]   cur_rate;
	logic [2:0]   prev_chans;
	logic [1:0]   prev_rate;
	logic [15:0]  skip_left;
	logic         dropping;

	// Frame bytes predicted but not yet seen on the frame channel, oldest first.
	frame_beat_t beats_due [$];

	// Run bookkeeping.
	int n_sent;
	int n_checked;
	int n_fwd;
	int n_drop;
	int n_rsv;
	int n_writes;
	int n_bad;
	int quiet_cycles;

	// Idle shaping: a calm side never waits between items.
	bit tx_calm;
	bit rx_calm;
	int tx_gap;

	// ------------------------------------------------------------------------
	// Decode helpers
	// ------------------------------------------------------------------------

	// Frame length in bytes. 48 kHz frames hold two words per kbit/s and
	// 32 kHz frames three; 44.1 kHz rounds down and odd size codes add a word.
	function automatic logic [11:0] frame_len_of(logic [5:0] fsize, logic [1:0] rate);
		int kbps;
		int words;
		kbps = KBPS[fsize[5:1]];
		case (rate)
			RATE_48K: words = 2 * kbps;
			RATE_44K: words = (kbps * 96000) / 44100 + int'(fsize[0]);
			default:  words = 3 * kbps;
		endcase
		return 12'(words * 2);
	endfunction

	function automatic logic [2:0] chans_of_mode(acmod_t acmod);
		case (acmod)
			ACM_DUAL:   return 3'd2;
			ACM_MONO:   return 3'd1;
			ACM_STEREO: return 3'd2;
			ACM_3F:     return 3'd3;
			ACM_2F1R:   return 3'd3;
			ACM_3F1R:   return 3'd4;
			ACM_2F2R:   return 3'd4;
			default:    return 3'd5;
		endcase
	endfunction

	// Bit of header byte 6 that carries the LFE flag: every optional
	// mix-level field ahead of it pushes it two bits lower.
	function automatic int lfe_pos(acmod_t acmod);
		int pos;
		pos = 4;
		if (acmod[0] && acmod != ACM_MONO) pos -= 2;
		if (acmod[2]) pos -= 2;
		if (acmod == ACM_STEREO) pos -= 2;
		return pos;
	endfunction

	function automatic string beat_text(frame_beat_t b);
		return $sformatf("byte=%02h first=%0b last=%0b ch=%0d rate=%0d len=%0d chg=%0b",
			b.data, b.first, b.last, b.chans, b.rate, b.len, b.changed);
	endfunction

	// ------------------------------------------------------------------------
	// Parser model
	// ------------------------------------------------------------------------
	function automatic void reset_model();
		phase = SEEK_SYNC;
		foreach (hdr_buf[i]) hdr_buf[i] = '0;
		hdr_cnt = '0;
		body_left = '0;
		cur_len = '0;
		cur_chans = '0;
		cur_rate = '0;
		prev_chans = '0;
		prev_rate = RATE_RSV;
		skip_left = '0;
		dropping = 1'b0;
	endfunction

	function automatic void push_beat(logic [7:0] data, logic first, logic last, logic chg);
		frame_beat_t b;
		b.data = data;
		b.first = first;
		b.last = last;
		b.chans = cur_chans;
		b.rate = cur_rate;
		b.len = cur_len;
		b.changed = chg;
		beats_due.push_back(b);
	endfunction

	// Advance the sync hunt / header gather by one byte; true once the
	// seventh header byte is held.
	function automatic bit gather_byte(logic [7:0] b);
		if (hdr_cnt == 3'd0) begin
			if (b == SYNC_FIRST) begin
				hdr_buf[0] = b;
				hdr_cnt = 3'd1;
			end
			phase = SEEK_SYNC;
			return 1'b0;
		end
		if (hdr_cnt == 3'd1) begin
			if (b == SYNC_SECOND) begin
				hdr_buf[1] = b;
				hdr_cnt = 3'd2;
				phase = GATHER_HDR;
			end else if (b != SYNC_FIRST) begin
				hdr_cnt = 3'd0;
			end
			return 1'b0;
		end
		if (hdr_cnt >= 3'(HDR_BYTES)) hdr_cnt = 3'd0;
		hdr_buf[hdr_cnt] = b;
		hdr_cnt = hdr_cnt + 3'd1;
		return hdr_cnt == 3'(HDR_BYTES);
	endfunction

	function automatic void take_header();
		logic [7:0] s [HDR_BYTES];
		logic [1:0] rate;
		logic [5:0] fsize;
		acmod_t     acmod;
		logic [2:0] chans;
		logic       chg;
		s = hdr_buf;
		hdr_cnt = 3'd0;
		phase = SEEK_SYNC;
		rate = s[4][7:6];
		fsize = s[4][5:0];
		// Reserved rate or size code: throw the header away and hunt
		// again from the byte after the second sync byte.
		if (rate == RATE_RSV || fsize >= 6'(SIZE_CODES)) begin
			n_rsv++;
			for (int i = 2; i < HDR_BYTES; i++) void'(gather_byte(s[i]));
			return;
		end
		acmod = acmod_t'(s[6][7:5]);
		chans = chans_of_mode(acmod);
		if (s[6][lfe_pos(acmod)]) chans = chans + 3'd1;
		cur_rate = rate;
		cur_chans = chans;
		cur_len = frame_len_of(fsize, rate);
		chg = (chans != prev_chans) || (rate != prev_rate);
		// Dropped frames still move the format reference.
		prev_chans = chans;
		prev_rate = rate;
		dropping = (skip_left != 16'd0);
		if (dropping) skip_left = skip_left - 16'd1;
		body_left = cur_len - 12'(HDR_BYTES);
		phase = IN_BODY;
		if (dropping) begin
			n_drop++;
			return;
		end
		n_fwd++;
		for (int i = 0; i < HDR_BYTES; i++)
			push_beat(s[i], i == 0, 1'b0, (i == 0) ? chg : 1'b0);
	endfunction

	function automatic void predict_byte(logic [7:0] b);
		logic last;
		if (phase == IN_BODY) begin
			if (body_left != '0) body_left = body_left - 12'd1;
			last = (body_left == '0);
			if (last) begin
				phase = SEEK_SYNC;
				hdr_cnt = 3'd0;
			end
			if (!dropping) push_beat(b, 1'b0, last, 1'b0);
		end else begin
			if (phase != GATHER_HDR) phase = SEEK_SYNC;
			if (gather_byte(b)) take_header();
		end
	endfunction

	// ------------------------------------------------------------------------
	// Stream and configuration drivers
	// ------------------------------------------------------------------------

	// Offer one stream item after the drawn gap, hold it until accepted, then
	// run it through the model. Valid stays high so a back-to-back item can
	// follow in the same step; wait_drained lowers it.
	task automatic send_byte(input logic [7:0] b);
		if (tx_gap != 0) begin
			stream_valid <= 1'b0;
			repeat (tx_gap) @(posedge clk);
		end
		stream_valid <= 1'b1;
		stream_byte <= b;
		do @(posedge clk); while (!stream_ready);
		predict_byte(b);
		n_sent++;
		tx_gap = tx_calm ? 0 : $urandom_range(0, MAX_GAP);
	endtask

	// Hold the stream until every predicted frame byte has come out, then
	// let the parser finish any byte that produced nothing.
	task automatic wait_drained();
		stream_valid <= 1'b0;
		while (beats_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_skip(input logic [15:0] value);
		wait_drained();
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		skip_left = value;
		n_writes++;
	endtask

	// Send a well-formed frame; keep > 0 cuts it short after that many bytes.
	task automatic send_frame(input logic [1:0] rate, input logic [5:0] fsize,
		input acmod_t acmod, input logic lfe, input int keep);
		logic [7:0] mode_byte;
		int total;
		total = int'(frame_len_of(fsize, rate));
		if (keep > 0 && keep < total) total = keep;
		mode_byte = {acmod, 5'($urandom)};
		mode_byte[lfe_pos(acmod)] = lfe;
		send_byte(SYNC_FIRST);
		send_byte(SYNC_SECOND);
		send_byte(8'($urandom));
		send_byte(8'($urandom));
		send_byte({rate, fsize});
		send_byte(8'($urandom));
		send_byte(mode_byte);
		for (int i = HDR_BYTES; i < total; i++) send_byte(8'($urandom));
	endtask

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------

	// A 0x0B followed by anything but 0x77 drops the candidate, and a
	// repeated 0x0B restarts it.
	task automatic test_broken_sync();
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(SYNC_FIRST);
		send_byte(8'h12);
		send_byte(SYNC_SECOND);
		send_byte(SYNC_FIRST);
		send_byte(SYNC_FIRST);
	endtask

	task automatic test_reserved_codes();
		int len;
		// Reserved rate code.
		send_byte(SYNC_FIRST);
		send_byte(SYNC_SECOND);
		send_byte(8'hA5);
		send_byte(8'h5A);
		send_byte({RATE_RSV, 6'd0});
		send_byte(8'h00);
		send_byte(8'hE0);
		// Size codes just past the table and at the top of the field.
		send_byte(SYNC_FIRST);
		send_byte(SYNC_SECOND);
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte({RATE_48K, 6'(SIZE_CODES)});
		send_byte(8'h11);
		send_byte(8'h40);
		send_byte(SYNC_FIRST);
		send_byte(SYNC_SECOND);
		send_byte(8'h22);
		send_byte(8'h33);
		send_byte({RATE_32K, 6'h3F});
		send_byte(8'h44);
		send_byte(8'h55);
		// A sync word hidden in header bytes 2 and 3 of a rejected header
		// must be found on the rehunt; byte 6 of the rejected header then
		// becomes the size code of the real one. Being the first frame out
		// of reset, it flags a format change.
		send_byte(SYNC_FIRST);
		send_byte(SYNC_SECOND);
		send_byte(SYNC_FIRST);
		send_byte(SYNC_SECOND);
		send_byte({RATE_RSV, 6'd5});
		send_byte(8'h5A);
		send_byte({RATE_48K, 6'd1});
		send_byte(8'h3C);
		send_byte({ACM_STEREO, 5'b00100});
		len = int'(frame_len_of(6'd1, RATE_48K));
		for (int i = HDR_BYTES; i < len; i++) send_byte(8'($urandom));
	endtask

	// Skip count: a frame is consumed silently while it runs down; its new
	// format still becomes the reference for the next frame.
	task automatic test_skip_frames();
		write_skip(16'd1);
		send_frame(RATE_48K, 6'd0, ACM_3F2R, 1'b1, 0);
		wait_drained();
	endtask

	// Short random runs of noise, broken sync words and reserved headers.
	task automatic test_random_stream();
		int kind;
		int count;
		logic [7:0] b;
		logic [7:0] size_byte;
		for (int seq = 0; seq < RANDOM_SEQS; seq++) begin
			tx_calm = ($urandom_range(0, 3) == 0);
			rx_calm = ($urandom_range(0, 3) == 0);
			if (seq % 3 == 2)
				wait_drained();
			kind = $urandom_range(0, 99);
			if (kind < 40) begin
				count = $urandom_range(1, 20);
				for (int i = 0; i < count; i++) begin
					b = ($urandom_range(0, 4) == 0) ? SYNC_FIRST : 8'($urandom);
					if (b == SYNC_SECOND) b = 8'h76;
					send_byte(b);
				end
			end else if (kind < 70) begin
				b = 8'($urandom);
				if (b == SYNC_SECOND) b = 8'h76;
				send_byte(SYNC_FIRST);
				send_byte(b);
			end else begin
				if ($urandom_range(0, 1) == 0)
					size_byte = {RATE_RSV, 6'($urandom)};
				else
					size_byte = {2'($urandom_range(0, 2)), 6'($urandom_range(SIZE_CODES, 63))};
				send_byte(SYNC_FIRST);
				send_byte(SYNC_SECOND);
				send_byte(8'($urandom));
				send_byte(8'($urandom));
				send_byte(size_byte);
				send_byte(8'($urandom));
				send_byte(8'($urandom));
			end
		end
		tx_calm = 1'b0;
		rx_calm = 1'b0;
	endtask

	// Stream ends partway through a frame sent at full rate on both sides:
	// the header goes out with no format change after the dropped frame of
	// the same format, and the frame simply never finishes.
	task automatic test_truncated_end();
		write_skip(16'd0);
		tx_calm = 1'b1;
		rx_calm = 1'b1;
		send_frame(RATE_48K, 6'd4, ACM_3F2R, 1'b1, 24);
		tx_calm = 1'b0;
		rx_calm = 1'b0;
	endtask

	// ------------------------------------------------------------------------
	// Clock, frame sink, checker, watchdog
	// ------------------------------------------------------------------------
	initial begin
		forever #CLK_HALF clk = ~clk;
	end

	// Draw a stall before every frame item, drop ready for it, then hold
	// ready until the item is taken.
	initial begin : frame_sink
		int stall;
		do @(posedge clk); while (!arst_n);
		forever begin
			stall = rx_calm ? 0 : $urandom_range(0, MAX_GAP);
			if (stall != 0) begin
				frame_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			frame_ready <= 1'b1;
			do @(posedge clk); while (!frame_valid);
		end
	end

	// Compare every accepted frame item with the oldest prediction.
	always @(posedge clk) begin : frame_check
		frame_beat_t got;
		frame_beat_t want;
		if (arst_n && frame_valid && frame_ready) begin
			got.data = frame_byte;
			got.first = frame_first;
			got.last = frame_last;
			got.chans = channel_count;
			got.rate = rate_code;
			got.len = frame_length;
			got.changed = format_changed;
			n_checked++;
			if (beats_due.size() == 0) begin
				if (n_bad < REPORT_LIMIT)
					$display("unexpected frame item %0d: %s", n_checked, beat_text(got));
				n_bad++;
			end else begin
				want = beats_due.pop_front();
				if (got.data !== want.data || got.first !== want.first
					|| got.last !== want.last || got.chans !== want.chans
					|| got.rate !== want.rate || got.len !== want.len
					|| got.changed !== want.changed) begin
					if (n_bad < REPORT_LIMIT)
						$display("frame item %0d mismatch: expected %s, got %s",
							n_checked, beat_text(want), beat_text(got));
					n_bad++;
				end
			end
		end
	end

	// End the run if no channel moves an item for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((stream_valid && stream_ready) || (frame_valid && frame_ready)
				|| (cfg_valid && cfg_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= IDLE_LIMIT) begin
				$display("timeout: no item moved for %0d cycles, %0d predictions pending",
					IDLE_LIMIT, beats_due.size());
				$display("status: fail");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	initial begin
		n_sent = 0;
		n_checked = 0;
		n_fwd = 0;
		n_drop = 0;
		n_rsv = 0;
		n_writes = 0;
		n_bad = 0;
		quiet_cycles = 0;
		tx_calm = 1'b0;
		rx_calm = 1'b0;
		tx_gap = 0;
		reset_model();
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_broken_sync();
		test_reserved_codes();
		test_skip_frames();
		test_random_stream();
		test_truncated_end();

		// Drain, then give stray output a chance to show up.
		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (beats_due.size() != 0) begin
			$display("%0d predicted frame items never arrived", beats_due.size());
			n_bad += beats_due.size();
		end

		$display("covered %0d stream items: %0d frames forwarded, %0d dropped, %0d reserved headers",
			n_sent, n_fwd, n_drop, n_rsv);
		$display("checked %0d frame items across %0d skip-count writes, %0d failures",
			n_checked, n_writes, n_bad);
		if (n_bad == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/ac3sfp_pkg.sv
hw/rtl/ac3sfp_parse.sv
hw/rtl/ac3sfp_out.sv
hw/rtl/ac3_sync_frame_parser.sv
bench/tb_ac3_sync_frame_parser.sv
